/* hw/rtl/pcf_pkg.sv */
// Shared widths, register indexes, types and clipping helpers for the
// polynomial central force pipeline. Depends on nothing.
`timescale 1ns / 1ps

package pcf_pkg;

    localparam int POS_W       = 32;   // position and coefficient width
    localparam int OUT_W       = 48;   // potential and acceleration width
    localparam int R_W         = 32;   // radius width
    localparam int R2_W        = 64;   // squared radius width
    localparam int WIDE_W      = 51;   // headroom for sums ahead of clipping
    localparam int NUM_COEF    = 7;
    localparam int CFG_AW      = 3;
    localparam int TERMS_W     = 3;
    localparam int SQRT_STAGES = 16;   // two root bits per stage
    localparam int DIV_STEPS   = 24;   // two quotient bits per stage
    localparam int DIV_LAT     = DIV_STEPS + 2;

    // Register indexes of the configuration port
    localparam logic [CFG_AW-1:0] REG_NUM_TERMS = 3'd0;
    localparam logic [CFG_AW-1:0] REG_COEF_0    = 3'd1;

    // Magnitude clamp applied before the sign goes back on
    localparam logic [OUT_W:0] MAG_CLAMP = {1'b1, {OUT_W{1'b0}}};

    typedef struct packed {
        logic signed [POS_W-1:0] z;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] x;
    } t_pos;

    typedef struct packed {
        logic [OUT_W-1:0] val;
        logic             sat;
    } t_clip;

    // Clip a wide signed value to the 48-bit range and flag the clip
    function automatic t_clip clip48(input logic signed [WIDE_W-1:0] v);
        t_clip c;
        if ((&v[WIDE_W-1:OUT_W-1]) || !(|v[WIDE_W-1:OUT_W-1])) begin
            c.val = v[OUT_W-1:0];
            c.sat = 1'b0;
        end else begin
            c.val = v[WIDE_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
            c.sat = 1'b1;
        end
        return c;
    endfunction

    function automatic logic [POS_W-1:0] mag32(input logic signed [POS_W-1:0] v);
        return v[POS_W-1] ? POS_W'(-v) : POS_W'(v);
    endfunction

    function automatic logic [OUT_W-1:0] mag48(input logic signed [OUT_W-1:0] v);
        return v[OUT_W-1] ? OUT_W'(-v) : OUT_W'(v);
    endfunction

endpackage

/* hw/rtl/polynomial_central_force.sv */
// Top level of the polynomial central force pipeline: stream ports,
// configuration registers, Horner stages. Uses pcf_pkg, pcf_isqrt, pcf_divider.
`timescale 1ns / 1ps

// Takes one position word per clock unless the pipeline is held, and returns
// the potential sum a_k r^k and the radial acceleration in signed Q32.16.
// The pipeline holds the 16-stage square root, two stages per Horner term
// and the 26-stage divider of each acceleration lane. All stages advance
// together; when the output word is not taken the whole pipeline holds and
// input tready drops. Coefficients are read straight from the registers, so
// write them only while no word is in flight.
module polynomial_central_force import pcf_pkg::*; #(
    parameter int MAX_TERMS = 7,
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config port
    input  logic                  i_cfg_we,
    input  logic [CFG_AW-1:0]     i_cfg_addr,
    input  logic [POS_W-1:0]      i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [3*POS_W-1:0]    s_axis_tdata,   // pos_x, pos_y, pos_z
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [4*OUT_W-1:0]    m_axis_tdata,   // potential, acc_x, acc_y, acc_z
    output logic [1:0]            m_axis_tuser    // at_origin, saturated
);

    localparam int LAT    = 3 + SQRT_STAGES + 2 * MAX_TERMS + DIV_LAT;
    localparam int HALF_W = OUT_W / 2;
    localparam int PP_W   = HALF_W + R_W;
    localparam int PROD_W = PP_W + HALF_W;

    typedef struct packed {
        logic signed [OUT_W-1:0] p;
        logic                    sat;
        logic                    zero;
        logic                    fneg;
        logic                    xneg;
        logic                    yneg;
        logic                    zneg;
    } t_dside;

    logic                    w_ce;
    logic [LAT-1:0]          r_vld;
    logic [TERMS_W-1:0]      r_num_terms;
    logic signed [POS_W-1:0] r_coef [NUM_COEF];
    logic [TERMS_W-1:0]      w_n_use;

    // Hold every stage while the output word waits
    assign w_ce          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_ce;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_terms <= TERMS_W'(1);
            for (int k = 0; k < NUM_COEF; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_addr == REG_NUM_TERMS) begin
                r_num_terms <= i_cfg_data[TERMS_W-1:0];
            end else begin
                r_coef[i_cfg_addr - REG_COEF_0] <= $signed(i_cfg_data);
            end
        end
    end

    assign w_n_use = (r_num_terms > TERMS_W'(MAX_TERMS)) ? TERMS_W'(MAX_TERMS) : r_num_terms;

    // Valid bits travel beside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // Capture, square, sum
    t_pos            r_a_pos, r_b_pos, r_c_pos;
    logic [R2_W-1:0] r_b_sqx, r_b_sqy, r_b_sqz, r_c_r2;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_a_pos <= s_axis_tdata;
            r_b_pos <= r_a_pos;
            r_b_sqx <= R2_W'(mag32(r_a_pos.x)) * R2_W'(mag32(r_a_pos.x));
            r_b_sqy <= R2_W'(mag32(r_a_pos.y)) * R2_W'(mag32(r_a_pos.y));
            r_b_sqz <= R2_W'(mag32(r_a_pos.z)) * R2_W'(mag32(r_a_pos.z));
            r_c_pos <= r_b_pos;
            r_c_r2  <= r_b_sqx + r_b_sqy + r_b_sqz;
        end
    end

    // Square root, position delayed alongside
    logic [R_W-1:0] w_root;
    t_pos           r_sq_pos [SQRT_STAGES];

    pcf_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_rad  (r_c_r2),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_sq_pos[0] <= r_c_pos;
            for (int k = 1; k < SQRT_STAGES; k++) begin
                r_sq_pos[k] <= r_sq_pos[k-1];
            end
        end
    end

    // Horner stages: potential and derivative side by side
    logic [PP_W-1:0]         r_ha_plo [MAX_TERMS];
    logic [PP_W-1:0]         r_ha_phi [MAX_TERMS];
    logic [PP_W-1:0]         r_ha_flo [MAX_TERMS];
    logic [PP_W-1:0]         r_ha_fhi [MAX_TERMS];
    logic signed [OUT_W-1:0] r_ha_p   [MAX_TERMS];
    logic signed [OUT_W-1:0] r_ha_f   [MAX_TERMS];
    logic [R_W-1:0]          r_ha_r   [MAX_TERMS];
    t_pos                    r_ha_pos [MAX_TERMS];
    logic                    r_ha_sat [MAX_TERMS];
    logic signed [OUT_W-1:0] r_hb_p   [MAX_TERMS];
    logic signed [OUT_W-1:0] r_hb_f   [MAX_TERMS];
    logic [R_W-1:0]          r_hb_r   [MAX_TERMS];
    t_pos                    r_hb_pos [MAX_TERMS];
    logic                    r_hb_sat [MAX_TERMS];

    genvar j;
    generate
        for (j = 0; j < MAX_TERMS; j++) begin : g_horner
            localparam int K = MAX_TERMS - 1 - j;

            logic signed [OUT_W-1:0]  w_in_p, w_in_f;
            logic [R_W-1:0]           w_in_r;
            t_pos                     w_in_pos;
            logic                     w_in_sat;
            logic [OUT_W-1:0]         w_pmag, w_fmag;
            logic [PROD_W-1:0]        w_pprod, w_fprod, w_pshf, w_fshf;
            logic [OUT_W:0]           w_pm, w_fm;
            logic signed [WIDE_W-1:0] w_pt, w_ft, w_cp, w_cf;
            t_clip                    w_pc, w_fc;
            logic                     w_act_p, w_act_f;

            if (j == 0) begin : g_first
                assign w_in_p   = '0;
                assign w_in_f   = '0;
                assign w_in_r   = w_root;
                assign w_in_pos = r_sq_pos[SQRT_STAGES-1];
                assign w_in_sat = 1'b0;
            end else begin : g_next
                assign w_in_p   = r_hb_p[j-1];
                assign w_in_f   = r_hb_f[j-1];
                assign w_in_r   = r_hb_r[j-1];
                assign w_in_pos = r_hb_pos[j-1];
                assign w_in_sat = r_hb_sat[j-1];
            end

            assign w_pmag = mag48(w_in_p);
            assign w_fmag = mag48(w_in_f);

            // Half products of |p|*r and |f|*r
            always_ff @(posedge i_clk) begin
                if (w_ce) begin
                    r_ha_plo[j] <= PP_W'(w_pmag[HALF_W-1:0]) * PP_W'(w_in_r);
                    r_ha_phi[j] <= PP_W'(w_pmag[OUT_W-1:HALF_W]) * PP_W'(w_in_r);
                    r_ha_flo[j] <= PP_W'(w_fmag[HALF_W-1:0]) * PP_W'(w_in_r);
                    r_ha_fhi[j] <= PP_W'(w_fmag[OUT_W-1:HALF_W]) * PP_W'(w_in_r);
                    r_ha_p[j]   <= w_in_p;
                    r_ha_f[j]   <= w_in_f;
                    r_ha_r[j]   <= w_in_r;
                    r_ha_pos[j] <= w_in_pos;
                    r_ha_sat[j] <= w_in_sat;
                end
            end

            // Scale, clamp, restore sign, add coefficient, clip
            always_comb begin
                w_act_p = (TERMS_W'(K) < w_n_use);
                w_act_f = (K != 0) && w_act_p;
                w_pprod = {r_ha_phi[j], {HALF_W{1'b0}}} + PROD_W'(r_ha_plo[j]);
                w_fprod = {r_ha_fhi[j], {HALF_W{1'b0}}} + PROD_W'(r_ha_flo[j]);
                w_pshf  = w_pprod >> FRAC_BITS;
                w_fshf  = w_fprod >> FRAC_BITS;
                w_pm    = (w_pshf > PROD_W'(MAG_CLAMP)) ? MAG_CLAMP : w_pshf[OUT_W:0];
                w_fm    = (w_fshf > PROD_W'(MAG_CLAMP)) ? MAG_CLAMP : w_fshf[OUT_W:0];
                w_pt    = r_ha_p[j][OUT_W-1] ? -$signed({2'b00, w_pm}) : $signed({2'b00, w_pm});
                w_ft    = r_ha_f[j][OUT_W-1] ? -$signed({2'b00, w_fm}) : $signed({2'b00, w_fm});
                w_cp    = WIDE_W'(r_coef[K]);
                w_cf    = w_cp * WIDE_W'(K);
                w_pc    = clip48(w_pt + w_cp);
                w_fc    = clip48(w_ft + w_cf);
            end

            // Skip terms above the configured count
            always_ff @(posedge i_clk) begin
                if (w_ce) begin
                    r_hb_p[j]   <= w_act_p ? $signed(w_pc.val) : r_ha_p[j];
                    r_hb_f[j]   <= w_act_f ? $signed(w_fc.val) : r_ha_f[j];
                    r_hb_r[j]   <= r_ha_r[j];
                    r_hb_pos[j] <= r_ha_pos[j];
                    r_hb_sat[j] <= r_ha_sat[j] | (w_act_p & w_pc.sat) | (w_act_f & w_fc.sat);
                end
            end
        end
    endgenerate

    // Acceleration lanes
    logic signed [OUT_W-1:0] w_f;
    t_pos                    w_pos;
    logic [R_W-1:0]          w_r;
    logic [OUT_W-1:0]        w_qx, w_qy, w_qz;
    logic                    w_ox, w_oy, w_oz;
    t_dside                  r_ds [DIV_LAT];

    assign w_f   = r_hb_f[MAX_TERMS-1];
    assign w_pos = r_hb_pos[MAX_TERMS-1];
    assign w_r   = r_hb_r[MAX_TERMS-1];

    pcf_divider u_div_x (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_fmag (mag48(w_f)),
        .i_pmag (mag32(w_pos.x)),
        .i_r    (w_r),
        .o_quot (w_qx),
        .o_ovf  (w_ox)
    );

    pcf_divider u_div_y (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_fmag (mag48(w_f)),
        .i_pmag (mag32(w_pos.y)),
        .i_r    (w_r),
        .o_quot (w_qy),
        .o_ovf  (w_oy)
    );

    pcf_divider u_div_z (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_fmag (mag48(w_f)),
        .i_pmag (mag32(w_pos.z)),
        .i_r    (w_r),
        .o_quot (w_qz),
        .o_ovf  (w_oz)
    );

    // Delay potential, flags and signs across the divider
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_ds[0].p    <= r_hb_p[MAX_TERMS-1];
            r_ds[0].sat  <= r_hb_sat[MAX_TERMS-1];
            r_ds[0].zero <= (w_r == '0);
            r_ds[0].fneg <= w_f[OUT_W-1];
            r_ds[0].xneg <= w_pos.x[POS_W-1];
            r_ds[0].yneg <= w_pos.y[POS_W-1];
            r_ds[0].zneg <= w_pos.z[POS_W-1];
            for (int k = 1; k < DIV_LAT; k++) begin
                r_ds[k] <= r_ds[k-1];
            end
        end
    end

    // Sign and clip one lane; negative when force and position agree in sign
    function automatic t_clip acc_fin(input logic [OUT_W-1:0] q, input logic ovf,
                                      input logic neg, input logic zero);
        logic [OUT_W:0]           m;
        logic signed [WIDE_W-1:0] v;
        t_clip                    c;
        m = ovf ? MAG_CLAMP : {1'b0, q};
        v = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
        c = clip48(v);
        if (zero) begin
            c.val = '0;
            c.sat = 1'b0;
        end
        return c;
    endfunction

    t_dside           w_d;
    t_clip            w_ax, w_ay, w_az;
    logic [OUT_W-1:0] r_out_pot, r_out_ax, r_out_ay, r_out_az;
    logic             r_out_zero, r_out_sat, r_out_valid;

    assign w_d  = r_ds[DIV_LAT-1];
    assign w_ax = acc_fin(w_qx, w_ox, w_d.fneg == w_d.xneg, w_d.zero);
    assign w_ay = acc_fin(w_qy, w_oy, w_d.fneg == w_d.yneg, w_d.zero);
    assign w_az = acc_fin(w_qz, w_oz, w_d.fneg == w_d.zneg, w_d.zero);

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ce) begin
            r_out_valid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_out_pot  <= w_d.p;
            r_out_ax   <= w_ax.val;
            r_out_ay   <= w_ay.val;
            r_out_az   <= w_az.val;
            r_out_zero <= w_d.zero;
            r_out_sat  <= w_d.sat | w_ax.sat | w_ay.sat | w_az.sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_az, r_out_ay, r_out_ax, r_out_pot};
    assign m_axis_tuser  = {r_out_sat, r_out_zero};

endmodule

/* hw/rtl/pcf_isqrt.sv */
// Pipelined integer square root, two result bits per stage.
// Depends on pcf_pkg.
`timescale 1ns / 1ps

module pcf_isqrt import pcf_pkg::*; (
    input  logic            i_clk,
    input  logic            i_ce,
    input  logic [R2_W-1:0] i_rad,
    output logic [R_W-1:0]  o_root
);

    localparam int ITERS = R_W / SQRT_STAGES;

    typedef struct packed {
        logic [R_W+2:0]  rem;
        logic [R_W-1:0]  root;
        logic [R2_W-1:0] rad;
    } t_sq_st;

    // One digit of the root: bring down two radicand bits, try 4*root+1
    function automatic t_sq_st sq_iter(input t_sq_st s);
        logic [R_W+2:0] remn;
        logic [R_W+2:0] trial;
        t_sq_st         o;
        remn  = {s.rem[R_W:0], s.rad[R2_W-1 -: 2]};
        trial = {1'b0, s.root, 2'b01};
        o.rad = s.rad << 2;
        if (remn >= trial) begin
            o.rem  = remn - trial;
            o.root = {s.root[R_W-2:0], 1'b1};
        end else begin
            o.rem  = remn;
            o.root = {s.root[R_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_sq_st sq_stage(input t_sq_st s);
        t_sq_st t;
        t = s;
        for (int j = 0; j < ITERS; j++) begin
            t = sq_iter(t);
        end
        return t;
    endfunction

    t_sq_st r_st [SQRT_STAGES];

    genvar i;
    generate
        for (i = 0; i < SQRT_STAGES; i++) begin : g_stage
            t_sq_st w_src;
            if (i == 0) begin : g_first
                assign w_src = '{rem: '0, root: '0, rad: i_rad};
            end else begin : g_next
                assign w_src = r_st[i-1];
            end
            // advance one stage
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_st[i] <= sq_stage(w_src);
                end
            end
        end
    endgenerate

    assign o_root = r_st[SQRT_STAGES-1].root;

endmodule

/* hw/rtl/pcf_divider.sv */
// Pipelined divider for one acceleration lane: |f| * |pos| / r with an
// overflow flag when the quotient would not fit 48 bits. Depends on pcf_pkg.
`timescale 1ns / 1ps

module pcf_divider import pcf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_ce,
    input  logic [OUT_W-1:0] i_fmag,
    input  logic [POS_W-1:0] i_pmag,
    input  logic [R_W-1:0]   i_r,
    output logic [OUT_W-1:0] o_quot,
    output logic             o_ovf
);

    localparam int HALF_W = OUT_W / 2;
    localparam int PP_W   = HALF_W + POS_W;
    localparam int PROD_W = PP_W + HALF_W;
    localparam int ITERS  = OUT_W / DIV_STEPS;

    typedef struct packed {
        logic [R_W-1:0]   rem;
        logic [OUT_W-1:0] lo;
        logic [OUT_W-1:0] q;
        logic [R_W-1:0]   r;
        logic             ovf;
    } t_dv_st;

    // One restoring step: bring down a dividend bit, subtract r if it fits
    function automatic t_dv_st dv_iter(input t_dv_st s);
        logic [R_W:0] remn;
        t_dv_st       o;
        o      = s;
        remn   = {s.rem, s.lo[OUT_W-1]};
        o.lo   = s.lo << 1;
        if (remn >= {1'b0, s.r}) begin
            o.rem = R_W'(remn - {1'b0, s.r});
            o.q   = {s.q[OUT_W-2:0], 1'b1};
        end else begin
            o.rem = remn[R_W-1:0];
            o.q   = {s.q[OUT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_dv_st dv_stage(input t_dv_st s);
        t_dv_st t;
        t = s;
        for (int j = 0; j < ITERS; j++) begin
            t = dv_iter(t);
        end
        return t;
    endfunction

    logic [PP_W-1:0]   r_plo;
    logic [PP_W-1:0]   r_phi;
    logic [R_W-1:0]    r_r;
    logic [PROD_W-1:0] w_prod;
    t_dv_st            r_st [DIV_STEPS+1];

    // Split the 48x32 product into two half products
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_plo <= PP_W'(i_fmag[HALF_W-1:0]) * PP_W'(i_pmag);
            r_phi <= PP_W'(i_fmag[OUT_W-1:HALF_W]) * PP_W'(i_pmag);
            r_r   <= i_r;
        end
    end

    // Join the halves; the top bits seed the remainder
    assign w_prod = {r_phi, {HALF_W{1'b0}}} + PROD_W'(r_plo);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_st[0].rem <= w_prod[PROD_W-1 -: R_W];
            r_st[0].lo  <= w_prod[OUT_W-1:0];
            r_st[0].q   <= '0;
            r_st[0].r   <= r_r;
            r_st[0].ovf <= ({1'b0, w_prod[PROD_W-1:OUT_W]} >= {{(PROD_W-OUT_W-R_W+1){1'b0}}, r_r});
        end
    end

    genvar i;
    generate
        for (i = 1; i <= DIV_STEPS; i++) begin : g_step
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_st[i] <= dv_stage(r_st[i-1]);
                end
            end
        end
    endgenerate

    assign o_quot = r_st[DIV_STEPS].q;
    assign o_ovf  = r_st[DIV_STEPS].ovf;

endmodule

/* test/polynomial_central_force_tb.sv */
// Self-checking testbench for polynomial_central_force: random and directed
// positions under several coefficient sets, checked against an in-bench model.
// Depends on pcf_pkg and the polynomial_central_force RTL.
`timescale 1ns / 1ps

module polynomial_central_force_tb;
    import pcf_pkg::*;

    localparam longint LIM_HI = (64'sd1 <<< 47) - 1;
    localparam longint LIM_LO = -(64'sd1 <<< 47);
    localparam logic [127:0] MAG_TOP = 128'd1 << 48;
    localparam int SHIFT = 16;
    localparam int MAX_N = 7;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_AW-1:0] REG_COEF_LAST = REG_COEF_0 + CFG_AW'(MAX_N - 1);

    typedef struct {
        logic [OUT_W-1:0] potential;
        logic [OUT_W-1:0] acc_x;
        logic [OUT_W-1:0] acc_y;
        logic [OUT_W-1:0] acc_z;
        logic             at_origin;
        logic             saturated;
    } t_force;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_AW-1:0]    cfg_addr = '0;
    logic [POS_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [3*POS_W-1:0]   in_word = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [4*OUT_W-1:0]   out_word;
    logic [1:0]           out_flags;

    // shadow of the configuration registers
    logic [TERMS_W-1:0]   terms_cfg = 3'd1;
    longint               coef_cfg [MAX_N];

    logic [3*POS_W-1:0]   pending_pos [$];
    t_force               expected_force [$];
    bit                   steady = 1'b0;
    int                   errors = 0;
    int                   words_in = 0;
    int                   words_out = 0;
    int                   origin_seen = 0;
    int                   sat_seen = 0;
    int                   cycles = 0;

    polynomial_central_force DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_word),     // pos_x, pos_y, pos_z
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_word),    // potential, acc_x, acc_y, acc_z
        .m_axis_tuser  (out_flags)    // at_origin, saturated
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Integer square root, floor
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic bit beyond(input longint v);
        return (v > LIM_HI) || (v < LIM_LO);
    endfunction

    function automatic longint clip(input longint v);
        return v > LIM_HI ? LIM_HI : (v < LIM_LO ? LIM_LO : v);
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // (p * r) >> SHIFT toward zero, signed like p, plus c; unclipped
    function automatic longint horner_raw(input longint p, input logic [63:0] r,
                                          input longint c);
        logic [127:0] prod;
        logic [127:0] m;
        prod = {64'd0, magnitude(p)} * {64'd0, r};
        m = prod >> SHIFT;
        if (m > MAG_TOP) m = MAG_TOP;
        return (p < 0 ? -longint'(m[63:0]) : longint'(m[63:0])) + c;
    endfunction

    // -(f * pos) / r toward zero; unclipped
    function automatic longint pull_raw(input longint f, input longint pos,
                                        input logic [63:0] r);
        logic [127:0] q;
        q = ({64'd0, magnitude(f)} * {64'd0, magnitude(pos)}) / {64'd0, r};
        if (q > MAG_TOP) q = MAG_TOP;
        return ((f < 0) == (pos < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic t_force predict_force(input logic [3*POS_W-1:0] w);
        t_force       o;
        longint       pos [3];
        longint       g [3];
        longint       p;
        longint       f;
        longint       v;
        logic [63:0]  r2;
        logic [63:0]  r;
        int           n;
        bit           sat;
        sat = 1'b0;
        r2 = 0;
        for (int i = 0; i < 3; i++) begin
            pos[i] = longint'($signed(w[i*POS_W +: POS_W]));
            r2 = r2 + magnitude(pos[i]) * magnitude(pos[i]);
            g[i] = 0;
        end
        r = root_floor(r2);
        n = terms_cfg > MAX_N ? MAX_N : terms_cfg;
        p = 0;
        f = 0;
        for (int k = n - 1; k >= 0; k--) begin
            v = horner_raw(p, r, coef_cfg[k]);
            sat |= beyond(v);
            p = clip(v);
            if (k >= 1) begin
                v = horner_raw(f, r, longint'(k) * coef_cfg[k]);
                sat |= beyond(v);
                f = clip(v);
            end
        end
        if (r != 0) begin
            for (int i = 0; i < 3; i++) begin
                v = pull_raw(f, pos[i], r);
                sat |= beyond(v);
                g[i] = clip(v);
            end
        end
        o.potential = p[OUT_W-1:0];
        o.acc_x = g[0][OUT_W-1:0];
        o.acc_y = g[1][OUT_W-1:0];
        o.acc_z = g[2][OUT_W-1:0];
        o.at_origin = (r == 0);
        o.saturated = sat;
        return o;
    endfunction

    // Driver: predict each accepted word, then offer the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_force.push_back(predict_force(in_word));
                words_in++;
            end
            if (!in_valid || in_ready) begin
                if (pending_pos.size() > 0 && (steady || $urandom_range(99) >= 33)) begin
                    in_word <= pending_pos.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, compare each taken word with the oldest prediction
    always @(posedge i_clk) begin
        t_force e;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                words_out++;
                if (expected_force.size() == 0) begin
                    $error("result word with no prediction pending");
                    errors++;
                end else begin
                    e = expected_force.pop_front();
                    origin_seen += e.at_origin;
                    sat_seen += e.saturated;
                    if (out_word[0*OUT_W +: OUT_W] !== e.potential) begin
                        $error("potential: expected %h, got %h", e.potential,
                               out_word[0*OUT_W +: OUT_W]);
                        errors++;
                    end
                    if (out_word[1*OUT_W +: OUT_W] !== e.acc_x) begin
                        $error("acc_x: expected %h, got %h", e.acc_x, out_word[1*OUT_W +: OUT_W]);
                        errors++;
                    end
                    if (out_word[2*OUT_W +: OUT_W] !== e.acc_y) begin
                        $error("acc_y: expected %h, got %h", e.acc_y, out_word[2*OUT_W +: OUT_W]);
                        errors++;
                    end
                    if (out_word[3*OUT_W +: OUT_W] !== e.acc_z) begin
                        $error("acc_z: expected %h, got %h", e.acc_z, out_word[3*OUT_W +: OUT_W]);
                        errors++;
                    end
                    if (out_flags[0] !== e.at_origin) begin
                        $error("at_origin: expected %b, got %b", e.at_origin, out_flags[0]);
                        errors++;
                    end
                    if (out_flags[1] !== e.saturated) begin
                        $error("saturated: expected %b, got %b", e.saturated, out_flags[1]);
                        errors++;
                    end
                end
            end
            out_ready <= steady || ($urandom_range(99) >= 33);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [POS_W-1:0] data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        if (addr == REG_NUM_TERMS) terms_cfg <= data[TERMS_W-1:0];
        else coef_cfg[addr - REG_COEF_0] <= longint'($signed(data));
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every queued position is taken and every result is back
    task automatic drain();
        do @(posedge i_clk);
        while (pending_pos.size() != 0 || in_valid || expected_force.size() != 0);
    endtask

    // Coefficient drawn from full range, small range or zero
    function automatic logic [POS_W-1:0] draw_coef(input int style);
        case (style)
            0: return $urandom();
            1: return POS_W'($signed($urandom_range(262143)) - 131072);
            2: return POS_W'($signed($urandom_range(2047)) - 1024);
            default: return '0;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] draw_axis();
        case ($urandom_range(5))
            0, 1: return $urandom();
            2: return POS_W'($signed($urandom_range(1048575)) - 524288);
            3: return POS_W'($signed($urandom_range(4095)) - 2048);
            4: return '0;
            default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    task automatic load_set(input logic [TERMS_W-1:0] terms, input int style);
        write_reg(REG_NUM_TERMS, {(POS_W-TERMS_W)'($urandom() >> TERMS_W), terms});
        for (int k = 0; k < MAX_N; k++)
            write_reg(REG_COEF_0 + CFG_AW'(k), draw_coef(style));
    endtask

    initial begin
        logic [POS_W-1:0] edges [6];
        for (int k = 0; k < MAX_N; k++) coef_cfg[k] = 0;
        edges = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
                  32'hffff_0000, 32'h0000_0001};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: one term, zero coefficients
        pending_pos.push_back({32'h0003_0000, 32'h0, 32'h0004_0000});
        drain();

        // directed: all terms, mixed coefficients, axis extremes and origin
        write_reg(REG_NUM_TERMS, 32'd7);
        write_reg(REG_COEF_0, 32'h0002_0000);
        write_reg(REG_COEF_0 + 3'd1, 32'hffff_8000);
        write_reg(REG_COEF_0 + 3'd2, 32'h0000_4000);
        write_reg(REG_COEF_0 + 3'd3, 32'hffff_f000);
        write_reg(REG_COEF_0 + 3'd4, 32'h0000_0100);
        write_reg(REG_COEF_0 + 3'd5, 32'h7fff_ffff);
        write_reg(REG_COEF_LAST, 32'h8000_0000);
        for (int i = 0; i < 6; i++)
            pending_pos.push_back({edges[(i + 2) % 6], edges[(i + 1) % 6], edges[i]});
        pending_pos.push_back('0);
        pending_pos.push_back({3{32'h8000_0000}});
        pending_pos.push_back({3{32'h7fff_ffff}});
        drain();

        // directed: no terms in use, at origin and away from it
        write_reg(REG_NUM_TERMS, 32'd0);
        pending_pos.push_back('0);
        pending_pos.push_back({32'h0, 32'h0, 32'h0002_0000});
        drain();

        // directed: constant only, then small coefficients with all terms
        write_reg(REG_NUM_TERMS, 32'd1);
        pending_pos.push_back('0);
        pending_pos.push_back({32'h0, 32'h0001_0000, 32'h0});
        drain();
        load_set(3'd7, 2);
        for (int i = 0; i < 6; i++)
            pending_pos.push_back({draw_axis(), 32'h0000_8000 << i, 32'hffff_0000 >> i});
        drain();

        // random phases over term counts and coefficient ranges
        for (int ph = 0; ph < 11; ph++) begin
            if (ph == 4) steady = 1'b1;
            if (ph == 5) steady = 1'b0;
            load_set(ph < 8 ? TERMS_W'(ph) : TERMS_W'($urandom_range(7)),
                     ph == 9 ? 0 : $urandom_range(3));
            for (int i = 0; i < 64; i++)
                pending_pos.push_back({draw_axis(), draw_axis(), draw_axis()});
            drain();
        end

        repeat (80) @(posedge i_clk);
        $display("%0d positions sent, %0d results checked over 0..7 terms", words_in, words_out);
        $display("%0d at the origin, %0d with clipping", origin_seen, sat_seen);
        if (errors == 0 && expected_force.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/pcf_pkg.sv
hw/rtl/pcf_isqrt.sv
hw/rtl/pcf_divider.sv
hw/rtl/polynomial_central_force.sv
test/polynomial_central_force_tb.sv
